[rtl/fdts_pkg.sv]
// ----------------------------------------------------------------------------
// fdts_pkg
// Shared types and constants for the two-server FIFO dispatch block.
// ----------------------------------------------------------------------------
`default_nettype none

package fdts_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam int unsigned ID_W   = 16;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned LEN_W  = 4;
	localparam int unsigned SUM_W  = 32;
	localparam int unsigned DONE_W = 16;

	// one queued job
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] at;
		logic [LEN_W-1:0]  len;
	} job_rec_t;

	// one input item (one tick)
	typedef struct packed {
		logic             arrival;
		logic [LEN_W-1:0] job_length;
	} job_in_t;

	// one result item
	typedef struct packed {
		logic              start_a_valid;
		logic [ID_W-1:0]   start_a_id;
		logic [TICK_W-1:0] start_a_wait;
		logic              start_b_valid;
		logic [ID_W-1:0]   start_b_id;
		logic [TICK_W-1:0] start_b_wait;
		logic              finish_a;
		logic              finish_b;
		logic              dropped;
		logic [SUM_W-1:0]  wait_sum;
		logic [DONE_W-1:0] done_count;
	} result_t;

endpackage

`default_nettype wire

[rtl/fdts_if.sv]
// ----------------------------------------------------------------------------
// fdts_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdts_job_if;
	logic              valid;
	logic              ready;
	fdts_pkg::job_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fdts_res_if;
	logic              valid;
	logic              ready;
	fdts_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/fifo_dispatch_two_servers.sv]
// ----------------------------------------------------------------------------
// fifo_dispatch_two_servers
// Each accepted tick item's result item is registered. Throughput: one tick
// item per cycle while results drain; the queue is read through a two-port
// registered prefetch of the two head entries, the arriving job bypassed.
// Reset (arst_n low): queue empty, both servers free, counters and totals
// zero; the job store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_dispatch_two_servers #(
	parameter int unsigned QUEUE_DEPTH = fdts_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fdts_job_if.sink     job_in,
	fdts_res_if.source   res_out
);

	localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	// last slot index; also the fill level of a full ring (one slot kept open)
	localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);

	localparam int unsigned LEN_W  = fdts_pkg::LEN_W;
	localparam int unsigned TICK_W = fdts_pkg::TICK_W;
	localparam int unsigned SUM_W  = fdts_pkg::SUM_W;
	localparam int unsigned DONE_W = fdts_pkg::DONE_W;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + AW'(1);
	endfunction

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	logic [AW-1:0]              head_q, tail_q, cnt_q;
	logic [TICK_W-1:0]          tick_q;
	logic [fdts_pkg::ID_W-1:0]  next_id_q;
	logic [LEN_W-1:0]           rem_a_q, rem_b_q;   // zero means server free
	logic [SUM_W-1:0]           sum_q;
	logic [DONE_W-1:0]          done_q;

	// job store plus registered reads of the next two head slots
	fdts_pkg::job_rec_t         job_mem [QUEUE_DEPTH];
	fdts_pkg::job_rec_t         rd0_q, rd1_q;

	fdts_pkg::result_t          res_q;
	logic                       res_vld_q;

	// ------------------------------------------------------------------
	// Tick logic
	// ------------------------------------------------------------------
	logic                       fire;
	logic                       full, push, drop;
	logic [LEN_W-1:0]           len_eff;
	fdts_pkg::job_rec_t         in_rec, ent0, ent1, rec_a, rec_b;
	logic                       have1, have2;
	logic                       st_a, st_b;
	logic [TICK_W-1:0]          wait_a, wait_b;
	logic [LEN_W-1:0]           run_a, run_b, rem_a_d, rem_b_d;
	logic                       fin_a, fin_b;
	logic [SUM_W+1:0]           sum_ext;
	logic [SUM_W-1:0]           sum_d;
	logic [DONE_W+1:0]          done_ext;
	logic [DONE_W-1:0]          done_d;
	logic [AW-1:0]              h1, h2, head_d, tail_d, cnt_d;
	logic [AW:0]                cnt_w;
	logic [AW-1:0]              raddr0, raddr1;
	fdts_pkg::result_t          res_d;

	// a new tick may enter whenever the result slot is empty or draining
	assign job_in.ready = !res_vld_q || res_out.ready;
	assign fire         = job_in.valid && job_in.ready;

	always_comb begin
		full    = (cnt_q == PTR_LAST);
		push    = job_in.data.arrival && !full;
		drop    = job_in.data.arrival && full;
		// zero length is served as one tick
		len_eff = (job_in.data.job_length == '0) ? LEN_W'(1) : job_in.data.job_length;
		in_rec  = '{id: next_id_q, at: tick_q, len: len_eff};

		// jobs available this tick, counting the one arriving now
		have1 = (cnt_q != '0) || push;
		have2 = (cnt_q > AW'(1)) || ((cnt_q == AW'(1)) && push);

		// head entries: prefetched, or the arrival when it lands at that slot
		ent0 = (cnt_q == '0)     ? in_rec : rd0_q;
		ent1 = (cnt_q == AW'(1)) ? in_rec : rd1_q;

		// server one first, then server two takes whatever is now at the head
		st_a  = (rem_a_q == '0) && have1;
		st_b  = (rem_b_q == '0) && (st_a ? have2 : have1);
		rec_a = ent0;
		rec_b = st_a ? ent1 : ent0;

		wait_a = st_a ? (tick_q - rec_a.at) : '0;
		wait_b = st_b ? (tick_q - rec_b.at) : '0;

		// countdown after start; a one-tick job finishes right away
		run_a   = st_a ? rec_a.len : rem_a_q;
		run_b   = st_b ? rec_b.len : rem_b_q;
		fin_a   = (run_a == LEN_W'(1));
		fin_b   = (run_b == LEN_W'(1));
		rem_a_d = (run_a != '0) ? run_a - LEN_W'(1) : '0;
		rem_b_d = (run_b != '0) ? run_b - LEN_W'(1) : '0;

		// saturating totals; one clip after the two adds gives the same answer
		sum_ext  = {2'b00, sum_q} + (SUM_W+2)'(wait_a) + (SUM_W+2)'(wait_b);
		sum_d    = (sum_ext[SUM_W+1:SUM_W] != 2'b00) ? '1 : sum_ext[SUM_W-1:0];
		done_ext = {2'b00, done_q} + (DONE_W+2)'(fin_a) + (DONE_W+2)'(fin_b);
		done_d   = (done_ext[DONE_W+1:DONE_W] != 2'b00) ? '1 : done_ext[DONE_W-1:0];

		// ring pointers
		h1     = ptr_next(head_q);
		h2     = ptr_next(h1);
		head_d = (st_a && st_b) ? h2 : ((st_a || st_b) ? h1 : head_q);
		tail_d = push ? ptr_next(tail_q) : tail_q;
		cnt_w  = {1'b0, cnt_q} + (AW+1)'(push) - (AW+1)'(st_a) - (AW+1)'(st_b);
		cnt_d  = cnt_w[AW-1:0];

		// prefetch addresses for the next tick
		raddr0 = head_d;
		raddr1 = ptr_next(head_d);

		res_d.start_a_valid = st_a;
		res_d.start_a_id    = st_a ? rec_a.id : '0;
		res_d.start_a_wait  = wait_a;
		res_d.start_b_valid = st_b;
		res_d.start_b_id    = st_b ? rec_b.id : '0;
		res_d.start_b_wait  = wait_b;
		res_d.finish_a      = fin_a;
		res_d.finish_b      = fin_b;
		res_d.dropped       = drop;
		res_d.wait_sum      = sum_d;
		res_d.done_count    = done_d;
	end

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			cnt_q     <= '0;
			tick_q    <= '0;
			next_id_q <= '0;
			rem_a_q   <= '0;
			rem_b_q   <= '0;
			sum_q     <= '0;
			done_q    <= '0;
		end else if (fire) begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			cnt_q     <= cnt_d;
			tick_q    <= tick_q + TICK_W'(1);
			// a dropped arrival still uses up an id
			next_id_q <= next_id_q + fdts_pkg::ID_W'(job_in.data.arrival);
			rem_a_q   <= rem_a_d;
			rem_b_q   <= rem_b_d;
			sum_q     <= sum_d;
			done_q    <= done_d;
		end
	end

	// ------------------------------------------------------------------
	// Job store: one write, two registered reads with write forwarding
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (fire) begin
			if (push) begin
				job_mem[tail_q] <= in_rec;
			end
			rd0_q <= (push && (tail_q == raddr0)) ? in_rec : job_mem[raddr0];
			rd1_q <= (push && (tail_q == raddr1)) ? in_rec : job_mem[raddr1];
		end
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (fire) begin
			res_vld_q <= 1'b1;
		end else if (res_out.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign res_out.valid = res_vld_q;
	assign res_out.data  = res_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= PTR_LAST)
		else $error("queue fill above capacity");

	a_cnt_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) == (cnt_q == '0))
		else $error("fill count disagrees with ring pointers");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> res_vld_q)
		else $error("accepted tick produced no result");

	a_sum_mono: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> sum_q >= $past(sum_q))
		else $error("wait total decreased");

	a_done_step: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (DONE_W'(done_q - $past(done_q)) <= DONE_W'(2)))
		else $error("finished count jumped by more than two");

endmodule

`default_nettype wire

[sim/tb_fifo_dispatch_two_servers.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fifo_dispatch_two_servers
// Self-checking bench for the two-server FIFO dispatch block. A driver and a
// monitor run on opposite clock edges. The monitor keeps a behavioral copy of
// the queue and both servers, predicts one result per accepted tick item, and
// compares every field of each accepted result against the oldest prediction.
// Stimulus: directed corner ticks, random load bursts, a long result hold-off
// and a stretch with no idling.
// ----------------------------------------------------------------------------
module tb_fifo_dispatch_two_servers;

	localparam int unsigned QDEPTH    = fdts_pkg::QUEUE_DEPTH_DEF;
	localparam int unsigned ID_W      = fdts_pkg::ID_W;
	localparam int unsigned TICK_W    = fdts_pkg::TICK_W;
	localparam int unsigned LEN_W     = fdts_pkg::LEN_W;
	localparam int unsigned SUM_W     = fdts_pkg::SUM_W;
	localparam int unsigned DONE_W    = fdts_pkg::DONE_W;
	localparam int          HOLD_LEN  = 300;    // long result hold-off, in cycles
	localparam int          MAX_PRINT = 100;

	typedef enum int {LOAD_HEAVY, LOAD_LIGHT, LOAD_MIXED} load_t;

	logic clk;
	logic arst_n;

	fdts_job_if job_ch ();
	fdts_res_if res_ch ();

	fifo_dispatch_two_servers dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.job_in  (job_ch),
		.res_out (res_ch)
	);

	// ---------------------------------------------------------------- bench state
	fdts_pkg::job_in_t pending_q[$];     // tick items not yet put on the wire
	fdts_pkg::result_t due_q[$];         // predicted results, oldest first
	int unsigned pushed_cnt = 0;   // tick items queued by the stimulus
	int unsigned taken_cnt  = 0;   // tick items accepted by the block
	int unsigned err_cnt    = 0;
	logic        job_took   = 1'b0; // tick item accepted at the last rising edge

	bit src_idle_en = 1'b1;
	bit snk_idle_en = 1'b1;
	bit hold_req    = 1'b0;        // ask the sink for one long hold-off
	bit hold_done   = 1'b0;
	int hold_left   = 0;

	// ---------------------------------------------------------- predictor state
	fdts_pkg::job_rec_t jq_store [QDEPTH];
	int unsigned       jq_head  = 0;
	int unsigned       jq_tail  = 0;
	logic [TICK_W-1:0] tick_cnt = '0;
	logic [ID_W-1:0]   id_cnt   = '0;
	logic              srv_idle [2] = '{1'b1, 1'b1};
	logic [LEN_W-1:0]  srv_left [2] = '{'0, '0};
	logic [ID_W-1:0]   srv_job  [2] = '{'0, '0};
	logic [SUM_W-1:0]  wait_acc = '0;
	logic [DONE_W-1:0] done_acc = '0;

	// ------------------------------------------------------------------- clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------- checking
	task automatic report_error(input string msg);
		err_cnt++;
		if (err_cnt <= MAX_PRINT)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// ---------------------------------------------------------------- predictor
	function automatic int unsigned ring_step(input int unsigned p);
		return (p + 1 >= QDEPTH) ? 0 : p + 1;
	endfunction

	// Pull the head job onto server s if that server is free and the queue
	// holds something. Wait is taken modulo the tick width.
	task automatic start_job(input int s, output logic v, output logic [ID_W-1:0] id,
			output logic [TICK_W-1:0] w);
		fdts_pkg::job_rec_t j;
		v  = 1'b0;
		id = '0;
		w  = '0;
		if (srv_idle[s] && jq_head != jq_tail) begin
			j           = jq_store[jq_head];
			w           = tick_cnt - j.at;
			jq_head     = ring_step(jq_head);
			srv_idle[s] = 1'b0;
			srv_left[s] = j.len;
			srv_job[s]  = j.id;
			if (wait_acc > {SUM_W{1'b1}} - SUM_W'(w))
				wait_acc = '1;
			else
				wait_acc = wait_acc + SUM_W'(w);
			v  = 1'b1;
			id = j.id;
		end
	endtask

	// Count a busy server down; a job finishes when its count hits zero.
	task automatic end_service(input int s, output logic fin);
		fin = 1'b0;
		if (srv_left[s] != 0) begin
			srv_left[s] = srv_left[s] - 1'b1;
			if (srv_left[s] == 0) begin
				srv_idle[s] = 1'b1;
				if (done_acc != {DONE_W{1'b1}})
					done_acc = done_acc + 1'b1;
				fin = 1'b1;
			end
		end
	endtask

	task automatic dispatch_tick(input fdts_pkg::job_in_t t);
		fdts_pkg::result_t  r;
		fdts_pkg::job_rec_t e;
		logic             sv;
		logic [ID_W-1:0]  sid;
		logic [TICK_W-1:0] sw;
		logic             fin;
		r = '0;
		if (t.arrival) begin
			// zero length runs as one tick; a full ring drops but still burns an id
			if (ring_step(jq_tail) == jq_head) begin
				r.dropped = 1'b1;
			end else begin
				e.id              = id_cnt;
				e.at              = tick_cnt;
				e.len             = (t.job_length == '0) ? LEN_W'(1) : t.job_length;
				jq_store[jq_tail] = e;
				jq_tail           = ring_step(jq_tail);
			end
			id_cnt = id_cnt + 1'b1;
		end
		// server one first, then server two off the new head
		start_job(0, sv, sid, sw);
		r.start_a_valid = sv;
		r.start_a_id    = sid;
		r.start_a_wait  = sw;
		start_job(1, sv, sid, sw);
		r.start_b_valid = sv;
		r.start_b_id    = sid;
		r.start_b_wait  = sw;
		// a server freed here only picks up work on the next tick
		end_service(0, fin);
		r.finish_a = fin;
		end_service(1, fin);
		r.finish_b   = fin;
		r.wait_sum   = wait_acc;
		r.done_count = done_acc;
		tick_cnt     = tick_cnt + 1'b1;
		due_q.push_back(r);
	endtask

	// ------------------------------------------------------------------ monitor
	// Input acceptance is predicted before the output is checked, so the order
	// holds whatever the block's latency.
	always @(posedge clk) begin
		fdts_pkg::result_t want;
		fdts_pkg::result_t got;
		job_took <= job_ch.valid && job_ch.ready;
		if (arst_n) begin
			if (job_ch.valid && job_ch.ready) begin
				taken_cnt++;
				dispatch_tick(job_ch.data);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (due_q.size() == 0) begin
					report_error("result item with no prediction waiting");
				end else begin
					want = due_q.pop_front();
					got  = res_ch.data;
					check_field("start_a_valid", 32'(got.start_a_valid), 32'(want.start_a_valid));
					check_field("start_a_id",    32'(got.start_a_id),    32'(want.start_a_id));
					check_field("start_a_wait",  32'(got.start_a_wait),  32'(want.start_a_wait));
					check_field("start_b_valid", 32'(got.start_b_valid), 32'(want.start_b_valid));
					check_field("start_b_id",    32'(got.start_b_id),    32'(want.start_b_id));
					check_field("start_b_wait",  32'(got.start_b_wait),  32'(want.start_b_wait));
					check_field("finish_a",      32'(got.finish_a),      32'(want.finish_a));
					check_field("finish_b",      32'(got.finish_b),      32'(want.finish_b));
					check_field("dropped",       32'(got.dropped),       32'(want.dropped));
					check_field("wait_sum",      32'(got.wait_sum),      32'(want.wait_sum));
					check_field("done_count",    32'(got.done_count),    32'(want.done_count));
				end
			end
		end
	end

	// ------------------------------------------------------------------- driver
	// An offered item stays put until accepted; otherwise the next one goes out
	// unless this cycle is picked as an idle one.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!job_ch.valid || job_took) begin
				if (pending_q.size() != 0 &&
						!(src_idle_en && $urandom_range(99) < 16)) begin
					job_ch.valid <= 1'b1;
					job_ch.data  <= pending_q.pop_front();
				end else begin
					job_ch.valid <= 1'b0;
				end
			end
		end
	end

	// --------------------------------------------------------------------- sink
	// Random back-pressure, plus one long hold-off on request so the block
	// backs up and stalls its input.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				res_ch.ready <= 1'b0;
				hold_left    <= hold_left - 1;
			end else if (hold_req && !hold_done) begin
				res_ch.ready <= 1'b0;
				hold_left    <= HOLD_LEN;
				hold_done    <= 1'b1;
			end else begin
				res_ch.ready <= !(snk_idle_en && $urandom_range(99) < 16);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	task automatic push_tick(input logic arr, input logic [LEN_W-1:0] len);
		fdts_pkg::job_in_t t;
		t.arrival    = arr;
		t.job_length = len;
		pending_q.push_back(t);
		pushed_cnt++;
	endtask

	// Heavy bursts fill the ring and force drops, light ones drain it to empty.
	task automatic queue_random(input int n);
		int    burst;
		load_t mode;
		logic  arr;
		logic [LEN_W-1:0] len;
		while (n > 0) begin
			burst = $urandom_range(60, 10);
			if (burst > n)
				burst = n;
			mode = load_t'($urandom_range(2));
			repeat (burst) begin
				len = LEN_W'($urandom);
				case (mode)
					LOAD_HEAVY: begin
						arr = ($urandom_range(99) < 90);
						if (arr)
							len = LEN_W'($urandom_range(15, 8));
					end
					LOAD_LIGHT: begin
						arr = ($urandom_range(99) < 30);
						if (arr)
							len = LEN_W'($urandom_range(4));
					end
					default: begin
						arr = ($urandom_range(99) < 50);
					end
				endcase
				push_tick(arr, len);
			end
			n -= burst;
		end
	endtask

	// Sampled on the falling edge, when monitor updates have settled.
	task automatic wait_all_taken(input bit with_results);
		while (taken_cnt != pushed_cnt || (with_results && due_q.size() != 0))
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		arst_n       = 1'b0;
		job_ch.valid = 1'b0;
		job_ch.data  = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: empty-queue ticks (length ignored without arrival), zero
		// length, one-tick job, then long jobs until the ring fills and drops
		push_tick(1'b0, 4'h0);
		push_tick(1'b0, 4'hF);
		push_tick(1'b1, 4'h0);
		push_tick(1'b1, 4'h1);
		repeat (21)
			push_tick(1'b1, 4'hF);

		queue_random(250);

		// sender pauses until everything has come back
		wait_all_taken(1'b1);

		// long hold-off on the result side while the sender keeps offering
		queue_random(250);
		hold_req = 1'b1;
		wait_all_taken(1'b0);

		// stretch with no idling on either side
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		queue_random(250);
		wait_all_taken(1'b0);
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;

		wait_all_taken(1'b1);
		repeat (20) @(posedge clk);

		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest passing run
	initial begin
		#(64'd4_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
